[rtl/pcfw_pkg.sv]
// Shared constants, codes and control types for the PWM command failsafe watchdog.
package pcfw_pkg;

  localparam int CHANNELS = 16;
  localparam int NCH      = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int IDX_W    = (NCH > 1) ? $clog2(NCH) : 1;

  localparam int OP_W     = 2;
  localparam int CH_W     = 4;
  localparam int VALUE_W  = 17;
  localparam int PWM_W    = 16;
  localparam int CAUSE_W  = 2;
  localparam int TO_W     = 17;
  localparam int STAMP_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [OP_W-1:0] OP_CMD   = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  localparam logic [CAUSE_W-1:0] CAUSE_CMD       = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_NO_CMD    = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_NO_CHANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE   = 2'd3;

  localparam logic [PWM_W-1:0] LOW_LIMIT_RST  = 16'd0;
  localparam logic [PWM_W-1:0] HIGH_LIMIT_RST = 16'd65535;
  localparam logic [TO_W-1:0]  TIMEOUT_RST    = 17'd5000;
  localparam logic [PWM_W-1:0] FAILSAFE_RST   = 16'd0;

  typedef struct packed {
    logic load_item;
    logic tick;
    logic cmd_commit;
    logic scan_start;
    logic scan_step;
    logic pend_load;
    logic out_from_pend;
    logic out_last;
  } pcfw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cmd_emit;
    logic            timeout_zero;
    logic            expired;
    logic            scan_done;
  } pcfw_status_t;

endpackage

[rtl/pcfw_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface pcfw_item_if import pcfw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [CH_W-1:0]           channel;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, operation, channel, value, input ready);
  modport sink (input valid, operation, channel, value, output ready);
endinterface

interface pcfw_result_if import pcfw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel_out;
  logic [PWM_W-1:0]   pwm_value;
  logic [CAUSE_W-1:0] cause;
  logic               last;

  modport source (output valid, channel_out, pwm_value, cause, last, input ready);
  modport sink (input valid, channel_out, pwm_value, cause, last, output ready);
endinterface

[rtl/pwm_command_failsafe_watchdog.sv]
// Top level: PWM command filter with per-channel failsafe watchdog.
// A tick or command is loaded in S_IDLE and run in S_EXEC; a command result waits for a free output.
// A check with nonzero timeout runs the scan, which reads one channel stamp per cycle unless stalled.
// A full output register holds a command or the scan; check results trail the scan by one expired channel.
// Synchronous active-high reset clears the clock, all stamps and previous values, and
// loads the register defaults; no clearing pass is needed.
module pwm_command_failsafe_watchdog import pcfw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pcfw_item_if.sink             items,
  pcfw_result_if.source         results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pcfw_cmd_t    cmd;
  pcfw_status_t status;

  pcfw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .status    (status),
    .cmd       (cmd)
  );

  pcfw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_operation (items.operation),
    .in_channel   (items.channel),
    .in_value     (items.value),
    .cmd          (cmd),
    .status       (status),
    .channel_out  (results.channel_out),
    .pwm_value    (results.pwm_value),
    .cause        (results.cause),
    .last         (results.last)
  );

endmodule

[rtl/pcfw_ctrl.sv]
// Controller state machine: sequences items, the channel scan and the result register.
module pcfw_ctrl import pcfw_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         out_ready,
  output logic         out_valid,
  input  pcfw_status_t status,
  output pcfw_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       pend_valid;
  logic       pend_valid_next;
  logic       out_valid_next;
  logic       out_load;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    pend_valid_next = pend_valid;
    out_load        = 1'b0;
    in_ready        = 1'b0;
    cmd             = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.op)
          OP_TICK: begin
            cmd.tick   = 1'b1;
            state_next = S_IDLE;
          end
          OP_CMD: begin
            if (!status.cmd_emit) begin
              state_next = S_IDLE;
            end else if (out_free) begin
              cmd.cmd_commit = 1'b1;
              out_load       = 1'b1;
              state_next     = S_IDLE;
            end
          end
          OP_CHECK: begin
            if (status.timeout_zero) begin
              state_next = S_IDLE;
            end else begin
              cmd.scan_start  = 1'b1;
              pend_valid_next = 1'b0;
              state_next      = S_SCAN;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (!(status.expired && pend_valid && !out_free)) begin
          cmd.scan_step = 1'b1;
          if (status.expired) begin
            cmd.pend_load   = 1'b1;
            pend_valid_next = 1'b1;
            if (pend_valid) begin
              cmd.out_from_pend = 1'b1;
              out_load          = 1'b1;
            end
          end
          if (status.scan_done) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          cmd.out_from_pend = 1'b1;
          cmd.out_last      = 1'b1;
          out_load          = 1'b1;
          pend_valid_next   = 1'b0;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

[rtl/pcfw_dp.sv]
// Datapath: registers, millisecond clock, channel stamps, clamp, expiry compare, result register.
module pcfw_dp import pcfw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic [OP_W-1:0]           in_operation,
  input  logic [CH_W-1:0]           in_channel,
  input  logic signed [VALUE_W-1:0] in_value,
  input  pcfw_cmd_t                 cmd,
  output pcfw_status_t              status,
  output logic [CH_W-1:0]           channel_out,
  output logic [PWM_W-1:0]          pwm_value,
  output logic [CAUSE_W-1:0]        cause,
  output logic                      last
);

  logic [PWM_W-1:0]   low_limit;
  logic [PWM_W-1:0]   high_limit;
  logic [TO_W-1:0]    timeout;
  logic [PWM_W-1:0]   failsafe;
  logic [STAMP_W-1:0] clock_ms;
  logic [STAMP_W-1:0] set_stamp [NCH];
  logic [STAMP_W-1:0] change_stamp [NCH];
  logic [PWM_W-1:0]   previous_value [NCH];

  logic [OP_W-1:0]    item_op;
  logic [CH_W-1:0]    item_ch;
  logic [VALUE_W-1:0] item_value;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   pend_ch;

  logic [IDX_W-1:0]   cmd_idx;
  logic [PWM_W-1:0]   uv;
  logic               ch_ok;
  logic               changed;
  logic [PWM_W-1:0]   clamped;
  logic               timeout_pos;
  logic [TO_W-1:0]    mag;
  logic [STAMP_W-1:0] stamp_sel;
  logic [STAMP_W-1:0] elapsed;
  logic [CAUSE_W-1:0] scan_cause;

  assign cmd_idx     = item_ch[IDX_W-1:0];
  assign uv          = item_value[PWM_W-1:0];
  assign ch_ok       = {1'b0, item_ch} < (CH_W+1)'(NCH);
  assign changed     = uv != previous_value[cmd_idx];
  assign timeout_pos = !timeout[TO_W-1] && (timeout != '0);
  assign mag         = timeout[TO_W-1] ? (~timeout + 1'b1) : timeout;
  assign stamp_sel   = timeout_pos ? set_stamp[idx] : change_stamp[idx];
  assign elapsed     = clock_ms - stamp_sel;
  assign scan_cause  = timeout_pos ? CAUSE_NO_CMD : CAUSE_NO_CHANGE;

  always_comb begin
    if (uv > high_limit) begin
      clamped = high_limit;
    end else if (uv < low_limit) begin
      clamped = low_limit;
    end else begin
      clamped = uv;
    end
  end

  assign status.op           = item_op;
  assign status.timeout_zero = timeout == '0;
  assign status.cmd_emit     = !item_value[VALUE_W-1] && ch_ok &&
                               (changed || timeout == '0);
  assign status.expired      = elapsed > {{(STAMP_W-TO_W){1'b0}}, mag};
  assign status.scan_done    = idx == IDX_W'(NCH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= LOW_LIMIT_RST;
      high_limit <= HIGH_LIMIT_RST;
      timeout    <= TIMEOUT_RST;
      failsafe   <= FAILSAFE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_LIMIT:  low_limit  <= cfg_data[PWM_W-1:0];
        REG_HIGH_LIMIT: high_limit <= cfg_data[PWM_W-1:0];
        REG_TIMEOUT:    timeout    <= cfg_data[TO_W-1:0];
        REG_FAILSAFE:   failsafe   <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms <= '0;
      for (int i = 0; i < NCH; i++) begin
        set_stamp[i]      <= '0;
        change_stamp[i]   <= '0;
        previous_value[i] <= '0;
      end
    end else begin
      if (cmd.tick) begin
        clock_ms <= clock_ms + 1'b1;
      end
      if (cmd.cmd_commit) begin
        set_stamp[cmd_idx]      <= clock_ms;
        previous_value[cmd_idx] <= uv;
        if (changed) begin
          change_stamp[cmd_idx] <= clock_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op    <= in_operation;
      item_ch    <= in_channel;
      item_value <= in_value;
    end
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
    end
    if (cmd.pend_load) begin
      pend_ch <= idx;
    end
    if (cmd.cmd_commit) begin
      channel_out <= item_ch;
      pwm_value   <= clamped;
      cause       <= CAUSE_CMD;
      last        <= 1'b1;
    end else if (cmd.out_from_pend) begin
      channel_out <= CH_W'(pend_ch);
      pwm_value   <= failsafe;
      cause       <= scan_cause;
      last        <= cmd.out_last;
    end
  end

endmodule
